>>> sv/dep_pkg.sv
// Package: shared types and constants of the prediction error block.
`timescale 1ns / 1ps
package dep_pkg;
    localparam logic [1:0] KIND_WEIGHT = 2'd0;
    localparam logic [1:0] KIND_INPUT  = 2'd1;
    localparam logic [1:0] KIND_OUTPUT = 2'd2;
    localparam logic [1:0] KIND_TRIAL  = 2'd3;

    localparam logic [1:0] REG_IN_CH  = 2'd0;
    localparam logic [1:0] REG_OUT_CH = 2'd1;
    localparam logic [1:0] REG_TAPS   = 2'd2;
    localparam logic [1:0] REG_DELAY  = 2'd3;

    localparam int FRAC_BITS = 12;
    localparam int ACC_BITS  = 40;
    localparam int COUNT_BITS = 7;

    // one job handed from front to back
    typedef struct packed {
        logic [2:0]  channel;
        logic [15:0] y;
        logic        short_hist;
        logic [6:0]  frame_ptr;
    } job_t;
endpackage

>>> sv/dep_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
`timescale 1ns / 1ps
module dep_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

>>> sv/dep_front.sv
// Front end: decode items, update frame state, queue output jobs.
`timescale 1ns / 1ps
module dep_front (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  kind,
    input  logic [8:0]  index,
    input  logic [15:0] value,
    input  logic        frame_end,
    input  logic [3:0]  m_cnt,
    input  logic [3:0]  n_cnt,
    input  logic [3:0]  d_cnt,
    input  logic [4:0]  tau,
    output logic        w_we,
    output logic [8:0]  w_waddr,
    output logic        h_we,
    output logic [9:0]  h_waddr,
    output logic [15:0] wdata,
    output logic        job_valid,
    output dep_pkg::job_t job,
    input  logic        job_take,
    input  logic        back_busy
);
    logic [6:0] count_reg, count_next;
    logic [6:0] fptr_reg, fptr_next;
    dep_pkg::job_t q_reg [2];
    logic [1:0] q_cnt_reg, q_cnt_next;
    logic       q_rd_reg, q_wr_reg;
    logic       acc, is_job, store_item;
    logic [7:0] need;

    // hold store writes while a queued or running job still has to read the stores
    assign store_item = kind == dep_pkg::KIND_WEIGHT || kind == dep_pkg::KIND_INPUT;
    assign full = (q_cnt_reg == 2'd2) || (store_item && (job_valid || back_busy));
    assign acc  = push && !full;
    assign need = 8'({3'd0, tau} * {4'd0, d_cnt - 4'd1}) + 8'd1;
    assign is_job = acc && kind == dep_pkg::KIND_OUTPUT && index < {5'd0, n_cnt};

    assign w_we    = acc && kind == dep_pkg::KIND_WEIGHT;
    assign w_waddr = index;
    assign h_we    = acc && kind == dep_pkg::KIND_INPUT && index < {5'd0, m_cnt};
    assign h_waddr = {fptr_reg, index[2:0]};
    assign wdata   = value;

    // frame bookkeeping
    always_comb
    begin
        count_next = count_reg;
        fptr_next  = fptr_reg;
        if (acc && kind == dep_pkg::KIND_INPUT && frame_end)
        begin
            fptr_next = fptr_reg + 7'd1;
            if (count_reg != 7'd127)
            begin
                count_next = count_reg + 7'd1;
            end
        end
        else if (acc && kind == dep_pkg::KIND_TRIAL)
        begin
            count_next = '0;
        end
    end

    assign q_cnt_next = q_cnt_reg + {1'b0, is_job} - {1'b0, job_take};
    assign job_valid  = q_cnt_reg != 2'd0;
    assign job        = q_reg[q_rd_reg];

    // advance state and job queue
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            fptr_reg  <= '0;
            q_cnt_reg <= '0;
            q_rd_reg  <= 1'b0;
            q_wr_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            fptr_reg  <= fptr_next;
            q_cnt_reg <= q_cnt_next;
            if (job_take)
            begin
                q_rd_reg <= !q_rd_reg;
            end
            if (is_job)
            begin
                q_wr_reg <= !q_wr_reg;
            end
        end
    end

    // job payload
    always_ff @(posedge clk)
    begin
        if (is_job)
        begin
            q_reg[q_wr_reg].channel    <= index[2:0];
            q_reg[q_wr_reg].y          <= value;
            q_reg[q_wr_reg].short_hist <= {1'b0, count_reg} < need;
            q_reg[q_wr_reg].frame_ptr  <= fptr_reg;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) q_cnt_reg <= 2'd2)
        else $error("job queue overflow");
    assert property (@(posedge clk) disable iff (!rst_n) job_take |-> job_valid)
        else $error("job taken from empty queue");
    assert property (@(posedge clk) disable iff (!rst_n) full |-> !w_we && !h_we)
        else $error("store written while full");
endmodule

>>> sv/dep_back.sv
// Back end: one shared MAC sweeps taps and channels, rounds and saturates.
`timescale 1ns / 1ps
module dep_back (
    input  logic        clk,
    input  logic        rst_n,
    input  logic [3:0]  m_cnt,
    input  logic [3:0]  n_cnt,
    input  logic [3:0]  d_cnt,
    input  logic [4:0]  tau,
    input  logic        job_valid,
    input  dep_pkg::job_t job,
    output logic        job_take,
    output logic        busy,
    output logic [8:0]  w_raddr,
    input  logic [15:0] w_rdata,
    output logic [9:0]  h_raddr,
    input  logic [15:0] h_rdata,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  channel,
    output logic [15:0] error_value,
    output logic        saturated,
    output logic        history_short
);
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_DONE  = 2'd2;
    localparam logic [1:0] ST_ROUND = 2'd3;

    logic [1:0]  state_reg;
    logic [2:0]  j_reg, m_reg;
    logic [6:0]  fr_reg;
    logic        rd_v_reg, pr_v_reg, last_rd_reg, last_pr_reg;
    logic signed [31:0] prod_reg;
    logic signed [39:0] acc_reg;
    dep_pkg::job_t cur_reg;
    logic        out_v_reg;
    logic        last_addr;
    logic [8:0]  wa;
    logic signed [39:0] rnd;
    logic signed [27:0] res;

    assign last_addr = ({1'b0, m_reg} == m_cnt - 4'd1) && ({1'b0, j_reg} == d_cnt - 4'd1);
    assign wa = ({6'd0, j_reg} * {5'd0, m_cnt} + {6'd0, m_reg}) * {5'd0, n_cnt}
              + {6'd0, cur_reg.channel};
    assign w_raddr = wa;
    assign h_raddr = {fr_reg, m_reg};
    assign job_take = state_reg == ST_IDLE && job_valid && !out_v_reg;
    assign busy = state_reg != ST_IDLE;

    assign rnd = acc_reg + 40'sd2048;
    assign res = rnd[39:12];
    assign empty = !out_v_reg;

    // sequencer, MAC pipeline and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            rd_v_reg  <= 1'b0;
            pr_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            rd_v_reg <= 1'b0;
            pr_v_reg <= rd_v_reg;
            if (pop && out_v_reg)
            begin
                out_v_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (job_take)
                    begin
                        if (job.short_hist)
                        begin
                            out_v_reg <= 1'b1;
                        end
                        else
                        begin
                            state_reg <= ST_RUN;
                        end
                    end
                end
                ST_RUN:
                begin
                    rd_v_reg <= 1'b1;
                    if (last_addr)
                    begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE:
                begin
                    if (pr_v_reg && last_pr_reg)
                    begin
                        state_reg <= ST_ROUND;
                    end
                end
                ST_ROUND:
                begin
                    out_v_reg <= 1'b1;
                    state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        last_rd_reg <= last_addr;
        last_pr_reg <= last_rd_reg;
        prod_reg <= $signed(w_rdata) * $signed(h_rdata);
        if (job_take)
        begin
            cur_reg <= job;
            j_reg   <= '0;
            m_reg   <= '0;
            fr_reg  <= job.frame_ptr - 7'd1;
            acc_reg <= {{12{job.y[15]}}, job.y, 12'd0};
            channel <= job.channel;
            history_short <= job.short_hist;
            saturated <= 1'b0;
            error_value <= job.y;
        end
        else
        begin
            if (state_reg == ST_RUN)
            begin
                if ({1'b0, m_reg} == m_cnt - 4'd1)
                begin
                    m_reg  <= '0;
                    j_reg  <= j_reg + 3'd1;
                    fr_reg <= fr_reg - {2'd0, tau};
                end
                else
                begin
                    m_reg <= m_reg + 3'd1;
                end
            end
            if (pr_v_reg)
            begin
                acc_reg <= acc_reg - 40'(prod_reg);
            end
            // round and clip the finished sum
            if (state_reg == ST_ROUND)
            begin
                if (res > 28'sd32767)
                begin
                    error_value <= 16'h7fff;
                    saturated <= 1'b1;
                end
                else if (res < -28'sd32768)
                begin
                    error_value <= 16'h8000;
                    saturated <= 1'b1;
                end
                else
                begin
                    error_value <= res[15:0];
                    saturated <= 1'b0;
                end
            end
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) job_take |-> !out_v_reg)
        else $error("job started while result waits");
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_RUN |-> !out_v_reg)
        else $error("result valid during sweep");
    assert property (@(posedge clk) disable iff (!rst_n) pr_v_reg |-> $past(rd_v_reg))
        else $error("product without read");
endmodule

>>> sv/delay_embedded_prediction_error.sv
// Top level: registers, stores and the front/back halves.
//
// Usage: push items (kind, index, value, frame_end) while full is low;
// weight loads, input samples and trial restarts update state at once.
// An output sample with an in-range channel queues a job (two-deep).
// Results appear while empty is low and leave on pop.
// The back end runs one MAC over D*M weight/history pairs per job; a
// short-history job skips the sweep and passes its sample through.
// The sweep is set by the single read port of each store and the shared
// multiplier. A waiting result blocks the next job; output samples are
// accepted until the queue fills, then full rises. Weight loads and input
// samples see full high while any job is queued or in the MAC.
// Reset clears frame count, frame pointer, queue and result valid;
// registers reset to 1. Stores are undefined until written.
// Configuration writes (cfg_valid/cfg_ready) are always accepted;
// write them only while idle. Out-of-range values clamp.
`timescale 1ns / 1ps
module delay_embedded_prediction_error (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  kind,
    input  logic [8:0]  index,
    input  logic [15:0] value,
    input  logic        frame_end,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  channel,
    output logic [15:0] error_value,
    output logic        saturated,
    output logic        history_short,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [4:0]  cfg_data
);
    logic [3:0] in_ch_reg, out_ch_reg, taps_reg;
    logic [4:0] delay_reg;
    logic [3:0] m_cnt, n_cnt, d_cnt;
    logic [4:0] tau;
    logic w_we, h_we, job_valid, job_take, back_busy;
    logic [8:0] w_waddr, w_raddr;
    logic [9:0] h_waddr, h_raddr;
    logic [15:0] wdata, w_rdata, h_rdata;
    dep_pkg::job_t job;

    assign cfg_ready = 1'b1;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch_reg <= 4'd1;
            out_ch_reg <= 4'd1;
            taps_reg <= 4'd1;
            delay_reg <= 5'd1;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                dep_pkg::REG_IN_CH:  in_ch_reg <= cfg_data[3:0];
                dep_pkg::REG_OUT_CH: out_ch_reg <= cfg_data[3:0];
                dep_pkg::REG_TAPS:   taps_reg <= cfg_data[3:0];
                dep_pkg::REG_DELAY:  delay_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // clamp to 1..max
    assign m_cnt = in_ch_reg == 4'd0 ? 4'd1 : (in_ch_reg > 4'd8 ? 4'd8 : in_ch_reg);
    assign n_cnt = out_ch_reg == 4'd0 ? 4'd1 : (out_ch_reg > 4'd8 ? 4'd8 : out_ch_reg);
    assign d_cnt = taps_reg == 4'd0 ? 4'd1 : (taps_reg > 4'd8 ? 4'd8 : taps_reg);
    assign tau = delay_reg == 5'd0 ? 5'd1 : (delay_reg > 5'd16 ? 5'd16 : delay_reg);

    dep_front u_front (
        .clk, .rst_n, .push, .full, .kind, .index, .value, .frame_end,
        .m_cnt, .n_cnt, .d_cnt, .tau, .w_we, .w_waddr, .h_we, .h_waddr,
        .wdata, .job_valid, .job, .job_take, .back_busy
    );

    dep_ram #(.WIDTH(16), .DEPTH(512)) u_wram (
        .clk, .we(w_we), .waddr(w_waddr), .wdata, .raddr(w_raddr), .rdata(w_rdata)
    );

    dep_ram #(.WIDTH(16), .DEPTH(1024)) u_hram (
        .clk, .we(h_we), .waddr(h_waddr), .wdata, .raddr(h_raddr), .rdata(h_rdata)
    );

    dep_back u_back (
        .clk, .rst_n, .m_cnt, .n_cnt, .d_cnt, .tau, .job_valid, .job, .job_take,
        .busy(back_busy), .w_raddr, .w_rdata, .h_raddr, .h_rdata, .empty, .pop,
        .channel, .error_value, .saturated, .history_short
    );
endmodule

>>> dv/tb_top.sv
// Testbench for the delay-embedded prediction error block: scoreboard and stimulus.
`timescale 1ns / 1ps
module tb_top;
    typedef struct packed {
        logic [2:0]  channel;
        logic [15:0] error_value;
        logic        saturated;
        logic        history_short;
    } error_rec_t;

    // Tracks weights, input history and registers; predicts each error result.
    class error_scoreboard;
        logic signed [15:0] weights[512];
        logic signed [15:0] history[1024];
        int unsigned frame_cnt;
        int unsigned frame_ptr;
        logic [4:0] regs[4];
        error_rec_t expected_errors[$];
        int mismatches;

        function new();
            frame_cnt = 0;
            frame_ptr = 0;
            mismatches = 0;
            foreach (regs[i]) regs[i] = 5'd1;
        endfunction

        function int unsigned clamp(logic [4:0] v, int unsigned hi);
            if (v == 0) return 1;
            if (v > hi) return hi;
            return v;
        endfunction

        function void write_reg(logic [1:0] idx, logic [4:0] data);
            regs[idx] = (idx == dep_pkg::REG_DELAY) ? data : {1'b0, data[3:0]};
        endfunction

        function void note_input(logic [1:0] k, logic [8:0] idx, logic [15:0] v,
                                 logic fend);
            int unsigned nin, nout, taps, dly, need, fr;
            longint acc, res;
            error_rec_t rec;
            nin = clamp(regs[dep_pkg::REG_IN_CH], 8);
            nout = clamp(regs[dep_pkg::REG_OUT_CH], 8);
            taps = clamp(regs[dep_pkg::REG_TAPS], 8);
            dly = clamp(regs[dep_pkg::REG_DELAY], 16);
            case (k)
                dep_pkg::KIND_WEIGHT: weights[idx] = v;
                dep_pkg::KIND_INPUT:
                begin
                    if (idx < nin) history[frame_ptr * 8 + idx] = v;
                    if (fend)
                    begin
                        frame_ptr = (frame_ptr + 1) % 128;
                        if (frame_cnt < 127) frame_cnt++;
                    end
                end
                dep_pkg::KIND_TRIAL: frame_cnt = 0;
                default:
                begin
                    if (idx < nout)
                    begin
                        need = dly * (taps - 1) + 1;
                        rec.channel = idx[2:0];
                        rec.saturated = 1'b0;
                        rec.history_short = 1'b0;
                        if (frame_cnt < need)
                        begin
                            rec.error_value = v;
                            rec.history_short = 1'b1;
                        end
                        else
                        begin
                            acc = longint'($signed(v)) <<< dep_pkg::FRAC_BITS;
                            for (int j = 0; j < taps; j++)
                            begin
                                fr = (frame_ptr + 128 - 1 - j * dly) % 128;
                                for (int m = 0; m < nin; m++)
                                    acc -= longint'(weights[(j * nin + m) * nout + idx])
                                         * longint'(history[fr * 8 + m]);
                            end
                            res = (acc + 2048) >>> dep_pkg::FRAC_BITS;
                            if (res > 32767)
                            begin
                                res = 32767;
                                rec.saturated = 1'b1;
                            end
                            else if (res < -32768)
                            begin
                                res = -32768;
                                rec.saturated = 1'b1;
                            end
                            rec.error_value = res[15:0];
                        end
                        expected_errors.push_back(rec);
                    end
                end
            endcase
        endfunction

        function void check_result(error_rec_t got);
            error_rec_t exp_rec;
            if (expected_errors.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result: ch %0d err %0d",
                                               got.channel, $signed(got.error_value));
                return;
            end
            exp_rec = expected_errors.pop_front();
            if (got !== exp_rec)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: exp ch %0d err %0d sat %0b short %0b, %s",
                             exp_rec.channel, $signed(exp_rec.error_value),
                             exp_rec.saturated, exp_rec.history_short,
                             $sformatf("got ch %0d err %0d sat %0b short %0b",
                                       got.channel, $signed(got.error_value),
                                       got.saturated, got.history_short));
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [1:0]  kind = dep_pkg::KIND_WEIGHT;
    logic [8:0]  index = '0;
    logic [15:0] value = '0;
    logic        frame_end = 1'b0;
    logic        empty;
    logic        pop = 1'b0;
    logic [2:0]  channel;
    logic [15:0] error_value;
    logic        saturated;
    logic        history_short;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = dep_pkg::REG_IN_CH;
    logic [4:0]  cfg_data = '0;

    error_scoreboard sb = new();
    int pop_stall = 0;

    delay_embedded_prediction_error dut (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(99);
        if (r < 65) return 0;
        if (r < 95) return $urandom_range(3, 1);
        return $urandom_range(60, 15);
    endfunction

    // Monitor: note accepted inputs, check accepted results.
    always @(posedge clk)
    begin
        error_rec_t got;
        if (rst_n && push && !full) sb.note_input(kind, index, value, frame_end);
        if (rst_n && pop && !empty)
        begin
            got.channel = channel;
            got.error_value = error_value;
            got.saturated = saturated;
            got.history_short = history_short;
            sb.check_result(got);
        end
    end

    // Result side: stall at random.
    always @(posedge clk)
    begin
        if (pop_stall > 0)
        begin
            pop <= 1'b0;
            pop_stall <= pop_stall - 1;
        end
        else
        begin
            pop <= 1'b1;
            pop_stall <= gap_len();
        end
    end

    task automatic send(logic [1:0] k, logic [8:0] idx, logic [15:0] v, logic fend);
        int g;
        g = gap_len();
        if (g > 0)
        begin
            push <= 1'b0;
            repeat (g) @(posedge clk);
        end
        push <= 1'b1;
        kind <= k;
        index <= idx;
        value <= v;
        frame_end <= fend;
        do @(posedge clk); while (full);
    endtask

    // Hold off until every expected result has come, then let the back end drain.
    task automatic drain();
        push <= 1'b0;
        do @(posedge clk); while (sb.expected_errors.size() != 0);
        repeat (100) @(posedge clk);
    endtask

    task automatic write_cfg(logic [1:0] idx, logic [4:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
        sb.write_reg(idx, data);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_regs(logic [4:0] nin, logic [4:0] nout, logic [4:0] taps,
                            logic [4:0] dly);
        write_cfg(dep_pkg::REG_IN_CH, nin);
        write_cfg(dep_pkg::REG_OUT_CH, nout);
        write_cfg(dep_pkg::REG_TAPS, taps);
        write_cfg(dep_pkg::REG_DELAY, dly);
    endtask

    function automatic logic [15:0] rand_value();
        if ($urandom_range(1)) return 16'($urandom());
        return 16'($signed($urandom_range(8192)) - 4096);
    endfunction

    // Random traffic in a fresh trial: whole frames, output samples, loads, restarts.
    task automatic random_items(int n);
        int nin, nout, r;
        nin = sb.clamp(sb.regs[dep_pkg::REG_IN_CH], 8);
        nout = sb.clamp(sb.regs[dep_pkg::REG_OUT_CH], 8);
        send(dep_pkg::KIND_TRIAL, 9'($urandom()), 16'($urandom()), 1'($urandom()));
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(99);
            if (r < 35)
            begin
                for (int m = 0; m < nin; m++)
                begin
                    if ($urandom_range(9) == 0)
                        send(dep_pkg::KIND_INPUT, 9'($urandom_range(511, nin)),
                             rand_value(), 1'b0);
                    send(dep_pkg::KIND_INPUT, 9'(m), rand_value(), m == nin - 1);
                end
                i += nin - 1;
            end
            else if (r < 80)
                send(dep_pkg::KIND_OUTPUT,
                     ($urandom_range(9) != 0) ? 9'($urandom_range(nout - 1))
                     : 9'($urandom()), rand_value(), 1'($urandom()));
            else if (r < 97)
                send(dep_pkg::KIND_WEIGHT, 9'($urandom()), rand_value(), 1'($urandom()));
            else
                send(dep_pkg::KIND_TRIAL, 9'($urandom()), 16'($urandom()), 1'($urandom()));
        end
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Preload the weights in use and two channels of every history slot.
        set_regs(5'd2, 5'd2, 5'd2, 5'd1);
        for (int a = 0; a < 64; a++)
            send(dep_pkg::KIND_WEIGHT, 9'(a), rand_value(), 1'b0);
        for (int a = 0; a < 256; a++)
            send(dep_pkg::KIND_INPUT, 9'(a % 2), rand_value(), a % 2 == 1);
        drain();

        // Directed part: extremes, ignored items, saturation, short history.
        send(dep_pkg::KIND_OUTPUT, 9'd0, 16'h7fff, 1'b0);
        send(dep_pkg::KIND_OUTPUT, 9'd1, 16'h8000, 1'b1);
        send(dep_pkg::KIND_OUTPUT, 9'd2, 16'h1234, 1'b0);
        send(dep_pkg::KIND_OUTPUT, 9'd511, 16'h1234, 1'b0);
        send(dep_pkg::KIND_WEIGHT, 9'd0, 16'h8000, 1'b1);
        send(dep_pkg::KIND_WEIGHT, 9'd511, 16'h7fff, 1'b0);
        send(dep_pkg::KIND_INPUT, 9'd0, 16'h8000, 1'b0);
        send(dep_pkg::KIND_INPUT, 9'd1, 16'h7fff, 1'b1);
        send(dep_pkg::KIND_OUTPUT, 9'd0, 16'h7fff, 1'b0);
        send(dep_pkg::KIND_OUTPUT, 9'd0, 16'h8000, 1'b0);
        send(dep_pkg::KIND_INPUT, 9'd5, 16'h4000, 1'b1);
        send(dep_pkg::KIND_INPUT, 9'd300, 16'h4000, 1'b0);
        send(dep_pkg::KIND_INPUT, 9'd1, 16'hc000, 1'b1);
        send(dep_pkg::KIND_OUTPUT, 9'd1, 16'h0000, 1'b0);
        send(dep_pkg::KIND_TRIAL, 9'd0, 16'h0000, 1'b1);
        send(dep_pkg::KIND_OUTPUT, 9'd0, 16'h0100, 1'b0);
        send(dep_pkg::KIND_INPUT, 9'd0, 16'h0800, 1'b1);
        send(dep_pkg::KIND_OUTPUT, 9'd1, 16'hff00, 1'b0);
        send(dep_pkg::KIND_INPUT, 9'd1, 16'hf000, 1'b1);
        send(dep_pkg::KIND_OUTPUT, 9'd0, 16'h0001, 1'b0);
        send(dep_pkg::KIND_OUTPUT, 9'd1, 16'hffff, 1'b0);
        drain();

        // Random phases across several register settings, extremes and clamping included.
        random_items(40);
        drain();
        set_regs(5'd1, 5'd1, 5'd1, 5'd1);
        random_items(30);
        drain();
        set_regs(5'd15, 5'd0, 5'd3, 5'd31);
        random_items(40);
        drain();
        set_regs(5'd3, 5'd5, 5'd4, 5'd2);
        random_items(50);
        drain();
        set_regs(5'd8, 5'd8, 5'd1, 5'd16);
        random_items(50);
        drain();

        if (sb.mismatches == 0 && sb.expected_errors.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        #50ms;
        $display("FAILURE");
        $finish;
    end
endmodule
